/* design/iir_dft_pkg.sv */
// Shared widths, register indexes and reset constants of the direct form II IIR filter.
`timescale 1ns / 1ps
`default_nettype none
package iir_dft_pkg;

  localparam int SMP_W     = 16;   // audio sample width
  localparam int COEF_W    = 24;   // Q4.20 coefficient width
  localparam int DL_W      = 24;   // Q16.8 delay entry width
  localparam int NREGS     = 8;    // number of configuration registers
  localparam int CFG_IDX_W = 4;    // configuration index width, covers unused codes too
  localparam int REG_IDX_W = 3;    // width of a valid register index
  localparam int ACC_W     = 52;   // accumulator width
  localparam int MUL_A_W   = 32;   // wide operand of the shared multiplier
  localparam int PROD_W    = MUL_A_W + COEF_W;

  localparam logic signed [COEF_W-1:0] ONE_Q20 = 24'sd1048576;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_A1     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_A2     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_A3     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_B0     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_B1     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_B2     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_B3     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_INV_A0 = 3'd7;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [DL_W-1:0]   dl_t;
  typedef logic signed [SMP_W-1:0]  smp_t;

endpackage
`default_nettype wire

/* design/iir_dft_ifs.sv */
// Valid/ready channel interfaces for samples in, samples out and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface iir_dft_in_if import iir_dft_pkg::*; ();
  logic valid;
  logic ready;
  smp_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface iir_dft_out_if import iir_dft_pkg::*; ();
  logic valid;
  logic ready;
  smp_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface iir_dft_cfg_if import iir_dft_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  coef_t                data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/iir_direct_form_two.sv */
// Direct form II IIR filter with one shared multiply-accumulate unit.
//
// Usage:
//   in_ch  : one signed 16-bit audio sample per beat (sample_in).
//   out_ch : one filtered, saturated 16-bit sample per beat (sample_out).
//   cfg_ch : register writes, index 0..7 = a1, a2, a3, b0, b1, b2, b3, 1/a0,
//            all Q4.20. Indexes above 7 are dropped. Always ready; write only
//            while the filter is idle.
// Timing: an accepted sample runs through one 32x24 multiplier, one product a
//   cycle: min(TAPS-1,3) feedback products, min(TAPS,4) feed-forward products
//   and the output scale, plus fill and rounding steps. The result is
//   registered in the output register, and the next sample is taken only once
//   the sequencer is back in idle, so one sample is processed at a time.
// Stall: the result sits in an output register; a new sample is taken while
//   it waits. A finished result that finds the register still full holds the
//   sequencer until the receiver takes the old beat.
// Reset (rst_n low, synchronous): delay line cleared, b0 and 1/a0 set to 1.0,
//   other coefficients to 0, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module iir_direct_form_two
  import iir_dft_pkg::*;
#(
  parameter int TAPS = 4
) (
  input  wire             clk,
  input  wire             rst_n,
  iir_dft_in_if.sink      in_ch,
  iir_dft_out_if.source   out_ch,
  iir_dft_cfg_if.sink     cfg_ch
);

  // Only taps up to index 3 carry coefficients; the rest are not multiplied.
  localparam int NFB = (TAPS - 1 < 3) ? TAPS - 1 : 3;
  localparam int NFF = (TAPS < 4) ? TAPS : 4;
  localparam int CW  = (TAPS > 1) ? $clog2(TAPS) : 1;

  localparam logic signed [ACC_W-1:0]  HALF20 = ACC_W'(1) << 19;
  localparam logic signed [PROD_W-1:0] HALF28 = PROD_W'(1) << 27;
  localparam logic signed [ACC_W-1:0]  DL_MAX = ACC_W'((1 << (DL_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0]  DL_MIN = -(ACC_W'(1) << (DL_W - 1));
  localparam logic signed [PROD_W-1:0] SMP_MAX = PROD_W'((1 << (SMP_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SMP_MIN = -(PROD_W'(1) << (SMP_W - 1));

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_FB   = 9'b000000010,  // issue feedback products
    S_FBW  = 9'b000000100,  // drain last feedback product
    S_UPD  = 9'b000001000,  // write newest delay entry
    S_FF   = 9'b000010000,  // issue feed-forward products
    S_FFW  = 9'b000100000,  // drain last feed-forward product
    S_RND  = 9'b001000000,  // round feed-forward sum
    S_SCL  = 9'b010000000,  // multiply by 1/a0
    S_SAT  = 9'b100000000   // round, saturate, hand to output register
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic                      acc_en_r, acc_en_nxt;
  logic                      acc_sub_r, acc_sub_nxt;
  logic signed [MUL_A_W-1:0] t_r, t_nxt;
  logic                      out_valid_r, out_valid_nxt;
  smp_t                      out_smp_r, out_smp_nxt;

  coef_t cfg_r [NREGS];
  dl_t   dl_r  [TAPS];

  logic                      in_acc;
  logic                      upd_dl;
  logic [REG_IDX_W-1:0]      coef_idx;
  logic signed [MUL_A_W-1:0] mul_a;
  coef_t                     mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [PROD_W-1:0]  prod_rnd;
  dl_t                       dl_new;
  smp_t                      smp_sat;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign in_acc           = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.sample_out = out_smp_r;

  // Coefficient select: a(n) sits at n-1, b(n) at n+3.
  assign coef_idx = (state_r == S_FB) ? (REG_IDX_W'(cnt_r) - REG_IDX_W'(1))
                                      : (REG_IDX_W'(cnt_r) + REG_B0);

  // Shared multiplier
  assign mul_a = (state_r == S_SCL) ? t_r : MUL_A_W'(dl_r[cnt_r]);
  assign mul_b = (state_r == S_SCL) ? cfg_r[REG_INV_A0] : cfg_r[coef_idx];
  assign mul_p = mul_a * mul_b;

  // Half-up rounding of the accumulator and of the scaled product
  assign acc_rnd  = (acc_r + HALF20) >>> 20;
  assign prod_rnd = (prod_r + HALF28) >>> 28;

  always_comb begin
    if (acc_rnd > DL_MAX) begin
      dl_new = DL_MAX[DL_W-1:0];
    end else if (acc_rnd < DL_MIN) begin
      dl_new = DL_MIN[DL_W-1:0];
    end else begin
      dl_new = acc_rnd[DL_W-1:0];
    end
    if (prod_rnd > SMP_MAX) begin
      smp_sat = SMP_MAX[SMP_W-1:0];
    end else if (prod_rnd < SMP_MIN) begin
      smp_sat = SMP_MIN[SMP_W-1:0];
    end else begin
      smp_sat = prod_rnd[SMP_W-1:0];
    end
  end

  assign upd_dl = (state_r == S_UPD);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    acc_en_nxt    = 1'b0;
    acc_sub_nxt   = acc_sub_r;
    t_nxt         = t_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_smp_nxt   = out_smp_r;

    // Fold in the product issued last cycle
    if (acc_en_r) begin
      acc_nxt = acc_sub_r ? acc_r - ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          acc_nxt   = ACC_W'(in_ch.sample_in) <<< 28;
          cnt_nxt   = CW'(1);
          state_nxt = (NFB > 0) ? S_FB : S_UPD;
        end
      end
      S_FB: begin
        prod_nxt    = mul_p;
        acc_en_nxt  = 1'b1;
        acc_sub_nxt = 1'b1;
        if (cnt_r == CW'(NFB)) begin
          state_nxt = S_FBW;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_FBW: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_FF;
      end
      S_FF: begin
        prod_nxt    = mul_p;
        acc_en_nxt  = 1'b1;
        acc_sub_nxt = 1'b0;
        if (cnt_r == CW'(NFF - 1)) begin
          state_nxt = S_FFW;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_FFW: begin
        state_nxt = S_RND;
      end
      S_RND: begin
        t_nxt     = acc_rnd[MUL_A_W-1:0];
        state_nxt = S_SCL;
      end
      S_SCL: begin
        prod_nxt  = mul_p;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_smp_nxt   = smp_sat;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      acc_en_r    <= 1'b0;
      acc_sub_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      acc_en_r    <= acc_en_nxt;
      acc_sub_r   <= acc_sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    prod_r    <= prod_nxt;
    t_r       <= t_nxt;
    out_smp_r <= out_smp_nxt;
  end

  // Delay line: shift on the input beat, write the newest entry after feedback
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        dl_r[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        for (int i = TAPS - 1; i > 0; i--) begin
          dl_r[i] <= dl_r[i-1];
        end
      end
      if (upd_dl) begin
        dl_r[0] <= dl_new;
      end
    end
  end

  // Coefficient registers; drop writes to unused indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREGS; i++) begin
        cfg_r[i] <= '0;
      end
      cfg_r[REG_B0]     <= ONE_Q20;
      cfg_r[REG_INV_A0] <= ONE_Q20;
    end else if (cfg_ch.valid && cfg_ch.ready && (cfg_ch.index < CFG_IDX_W'(NREGS))) begin
      cfg_r[cfg_ch.index[REG_IDX_W-1:0]] <= cfg_ch.data;
    end
  end

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_FB) || (state_r == S_UPD))
    else $error("accepted sample did not start the sequencer");

  a_acc_only_in_sums: assert property (@(posedge clk) disable iff (!rst_n)
    acc_en_r |-> (state_r == S_FB) || (state_r == S_FBW) ||
                 (state_r == S_FF) || (state_r == S_FFW))
    else $error("accumulate outside a product run");

  a_ff_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FF) |-> (cnt_r <= CW'(NFF - 1)))
    else $error("feed-forward tap count out of range");

  a_sat_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SAT) && (!out_valid_r || out_ch.ready)) |=>
      out_valid_r && (state_r == S_IDLE))
    else $error("finished result not loaded into output register");

endmodule
`default_nettype wire
